FILE: design/sem_pkg.sv
// Shared constants, widths and control structs of the RGB Sobel edge block.
package sem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int FW_W  = 11;
	localparam int FH_W  = 13;
	localparam int PIX_W = 24;
	localparam int CH_W  = 8;
	localparam int IDX_W = 2;
	localparam int OWE_W = COL_W + 2;
	localparam int SQ_W  = 20;
	localparam int SUM_W = 21;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef struct packed {
		logic accept;
		logic rd;
		logic upd;
		logic calc;
		logic square;
		logic sum;
		logic root_init;
		logic root_step;
		logic round;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic drain_ok;
		logic tag_center;
		logic root_last;
		logic out_busy;
	} sts_t;

endpackage

FILE: design/sem_ctrl.sv
// Sequencer that steps one transaction through read, window update, gradient and root.
module sem_ctrl
	import sem_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic req_type,
	input  sts_t sts,
	output logic in_stall,
	output logic cfg_ready,
	output cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_UPD  = 4'd2;
	localparam logic [3:0] ST_CALC = 4'd3;
	localparam logic [3:0] ST_SQR  = 4'd4;
	localparam logic [3:0] ST_SUM  = 4'd5;
	localparam logic [3:0] ST_ROOT = 4'd6;
	localparam logic [3:0] ST_RND  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && (req_type == REQ_PIXEL || sts.drain_ok)) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = sts.tag_center ? ST_SQR : ST_IDLE;
			end
			ST_SQR: begin
				cmd.square = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum       = 1'b1;
				cmd.root_init = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_last) begin
					state_d = ST_RND;
				end
			end
			ST_RND: begin
				cmd.round = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

endmodule

FILE: design/sem_dp.sv
// Datapath: line memories, 3x3 window, positions, Sobel gradients, square root, output register.
module sem_dp
	import sem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic             req_type,
	input  logic [CH_W-1:0]  red_in,
	input  logic [CH_W-1:0]  green_in,
	input  logic [CH_W-1:0]  blue_in,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [FH_W-1:0]  cfg_data,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [CH_W-1:0]  red_out,
	output logic [CH_W-1:0]  green_out,
	output logic [CH_W-1:0]  blue_out,
	output logic             frame_last
);

	logic [PIX_W-1:0] mem_above [MAX_WIDTH];
	logic [PIX_W:0]   mem_mid   [MAX_WIDTH];

	logic [FW_W-1:0]  weff_q;
	logic [FH_W-1:0]  heff_q;
	logic [COL_W-1:0] col_ptr_q;
	logic [COL_W-1:0] k_q;
	logic [FW_W-1:0]  fill_q;
	logic [OWE_W-1:0] owed_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic             tag_right_q;
	logic             tag_center_q;
	logic [PIX_W-1:0] win_q [9];
	logic [PIX_W-1:0] px_q;
	logic             tag_q;
	logic [PIX_W-1:0] rd_a_q;
	logic [PIX_W:0]   rd_m_q;

	logic signed [FW_W-1:0] gx_q [3];
	logic signed [FW_W-1:0] gy_q [3];
	logic [SQ_W-1:0]        sqx_q [3];
	logic [SQ_W-1:0]        sqy_q [3];
	logic [15:0]            s_q [3];
	logic                   big_q [3];
	logic [CH_W-1:0]        root_q [3];
	logic [2:0]             bit_q;
	logic [CH_W-1:0]        mag_q [3];
	logic                   last_q;
	logic                   out_valid_q;
	logic [CH_W-1:0]        out_q [3];
	logic                   out_last_q;

	logic             restart;
	logic [COL_W-1:0] k_rd;
	logic [FW_W-1:0]  k_nx;
	logic             mt;
	logic             rok0;
	logic             rok2;
	logic             cok0;
	logic             cok2;
	logic [8:0]       ok;
	logic [FW_W-1:0]  in_col_nx;
	logic [FH_W-1:0]  in_row_nx;
	logic [FW_W-1:0]  out_col_nx;
	logic [FH_W-1:0]  out_row_nx;
	logic [FW_W-1:0]  wsel;
	logic [FH_W-1:0]  hsel;
	logic             do_out;

	assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_comb begin
		wsel = cfg_data[FW_W-1:0];
		if (wsel == '0) begin
			wsel = FW_W'(1);
		end else if (wsel > FW_W'(MAX_WIDTH)) begin
			wsel = FW_W'(MAX_WIDTH);
		end
		hsel = cfg_data;
		if (hsel == '0) begin
			hsel = FH_W'(1);
		end else if (hsel > FH_W'(MAX_HEIGHT)) begin
			hsel = FH_W'(MAX_HEIGHT);
		end
	end

	assign k_rd = ({1'b0, col_ptr_q} >= weff_q) ? '0 : col_ptr_q;
	assign k_nx = {1'b0, k_q} + FW_W'(1);
	assign mt   = rd_m_q[PIX_W] && (fill_q > {1'b0, k_q});

	assign in_col_nx  = {1'b0, in_col_q} + FW_W'(1);
	assign in_row_nx  = {1'b0, in_row_q} + FH_W'(1);
	assign out_col_nx = {1'b0, out_col_q} + FW_W'(1);
	assign out_row_nx = {1'b0, out_row_q} + FH_W'(1);

	assign rok0 = (out_row_q != '0);
	assign rok2 = (out_row_nx < heff_q);
	assign cok0 = (out_col_q != '0);
	assign cok2 = (out_col_nx < weff_q);
	assign ok   = {rok2 && cok2, rok2, rok2 && cok0,
	               cok2, 1'b1, cok0,
	               rok0 && cok2, rok0, rok0 && cok0};

	assign do_out = cmd.calc && tag_center_q;

	assign sts.drain_ok   = (in_row_q == '0) && (in_col_q == '0) && (owed_q != '0);
	assign sts.tag_center = tag_center_q;
	assign sts.root_last  = (bit_q == '0);
	assign sts.out_busy   = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_a_q <= mem_above[k_rd];
			rd_m_q <= mem_mid[k_rd];
		end
		if (cmd.upd) begin
			mem_above[k_q] <= rd_m_q[PIX_W-1:0];
			mem_mid[k_q]   <= {tag_q, px_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weff_q       <= FW_W'(MAX_WIDTH);
			heff_q       <= FH_W'(1024);
			col_ptr_q    <= '0;
			fill_q       <= '0;
			owed_q       <= '0;
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			tag_right_q  <= 1'b0;
			tag_center_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (restart) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				weff_q <= wsel;
			end else begin
				heff_q <= hsel;
			end
			col_ptr_q    <= '0;
			fill_q       <= '0;
			owed_q       <= '0;
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			tag_right_q  <= 1'b0;
			tag_center_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cmd.accept && req_type == REQ_PIXEL) begin
				owed_q <= owed_q + OWE_W'(1);
				if (in_col_nx >= weff_q) begin
					in_col_q <= '0;
					in_row_q <= (in_row_nx >= heff_q) ? '0 : in_row_nx[ROW_W-1:0];
				end else begin
					in_col_q <= in_col_nx[COL_W-1:0];
				end
			end
			if (cmd.upd) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2]     <= rd_a_q;
				win_q[5]     <= rd_m_q[PIX_W-1:0];
				win_q[8]     <= px_q;
				tag_center_q <= tag_right_q;
				tag_right_q  <= mt;
				col_ptr_q    <= (k_nx >= weff_q) ? '0 : k_nx[COL_W-1:0];
				if (fill_q < weff_q) begin
					fill_q <= fill_q + FW_W'(1);
				end
			end
			if (do_out) begin
				if (owed_q != '0) begin
					owed_q <= owed_q - OWE_W'(1);
				end
				if (out_col_nx >= weff_q) begin
					out_col_q <= '0;
					out_row_q <= (out_row_nx >= heff_q) ? '0 : out_row_nx[ROW_W-1:0];
				end else begin
					out_col_q <= out_col_nx[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q  <= (req_type == REQ_PIXEL) ? {blue_in, green_in, red_in} : '0;
			tag_q <= (req_type == REQ_PIXEL);
		end
		if (cmd.rd) begin
			k_q <= k_rd;
		end
		if (do_out) begin
			last_q <= !rok2 && !cok2;
		end
	end

	generate
		for (genvar c = 0; c < 3; c++) begin : g_ch
			logic [CH_W-1:0]      p [9];
			logic [CH_W+1:0]      gx_r;
			logic [CH_W+1:0]      gx_l;
			logic [CH_W+1:0]      gy_b;
			logic [CH_W+1:0]      gy_t;
			logic signed [21:0]   px2;
			logic signed [21:0]   py2;
			logic [SUM_W-1:0]     s;
			logic [CH_W-1:0]      trial;
			logic [15:0]          trial2;
			logic [16:0]          rr;

			always_comb begin
				for (int i = 0; i < 9; i++) begin
					p[i] = ok[i] ? win_q[i][c*CH_W +: CH_W] : '0;
				end
				gx_r  = {2'b0, p[2]} + {1'b0, p[5], 1'b0} + {2'b0, p[8]};
				gx_l  = {2'b0, p[0]} + {1'b0, p[3], 1'b0} + {2'b0, p[6]};
				gy_b  = {2'b0, p[6]} + {1'b0, p[7], 1'b0} + {2'b0, p[8]};
				gy_t  = {2'b0, p[0]} + {1'b0, p[1], 1'b0} + {2'b0, p[2]};
				px2   = gx_q[c] * gx_q[c];
				py2   = gy_q[c] * gy_q[c];
				s     = {1'b0, sqx_q[c]} + {1'b0, sqy_q[c]};
				trial = root_q[c] | (CH_W'(1) << bit_q);
				trial2 = trial * trial;
				rr    = {1'b0, 16'(root_q[c]) * 16'(root_q[c])} + {9'b0, root_q[c]};
			end

			always_ff @(posedge clk) begin
				if (cmd.calc) begin
					gx_q[c] <= $signed({1'b0, gx_r}) - $signed({1'b0, gx_l});
					gy_q[c] <= $signed({1'b0, gy_b}) - $signed({1'b0, gy_t});
				end
				if (cmd.square) begin
					sqx_q[c] <= px2[SQ_W-1:0];
					sqy_q[c] <= py2[SQ_W-1:0];
				end
				if (cmd.sum) begin
					s_q[c]   <= s[15:0];
					big_q[c] <= (s > SUM_W'(65025));
				end
				if (cmd.root_init) begin
					root_q[c] <= '0;
				end else if (cmd.root_step && trial2 <= s_q[c]) begin
					root_q[c] <= trial;
				end
				if (cmd.round) begin
					if (big_q[c]) begin
						mag_q[c] <= '1;
					end else begin
						mag_q[c] <= root_q[c] + CH_W'({16'b0, s_q[c]} > rr);
					end
				end
				if (cmd.load_out) begin
					out_q[c] <= mag_q[c];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			bit_q <= 3'd7;
		end else if (cmd.root_step) begin
			bit_q <= bit_q - 3'd1;
		end
		if (cmd.load_out) begin
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign red_out    = out_q[0];
	assign green_out  = out_q[1];
	assign blue_out   = out_q[2];
	assign frame_last = out_last_q;

endmodule

FILE: design/sobel_edge_magnitude_rgb.sv
// Top level of the streaming 3x3 Sobel RGB edge magnitude block.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | req_type, red_in, green_in, blue_in
//  out     | out_valid / out_stall | red_out, green_out, blue_out, frame_last
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A pixel transaction that yields a result steps through accept, read, window
// update, gradient, square, sum, 8 bit-serial root steps, round and output load;
// one that yields none ends after the gradient step. An ignored drain is dropped in idle.
// Reset leaves width and height at 1024 and needs no clearing pass. A stalled
// output holds the sequencer only in its final load step.
module sobel_edge_magnitude_rgb
	import sem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             req_type,
	input  logic [CH_W-1:0]  red_in,
	input  logic [CH_W-1:0]  green_in,
	input  logic [CH_W-1:0]  blue_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CH_W-1:0]  red_out,
	output logic [CH_W-1:0]  green_out,
	output logic [CH_W-1:0]  blue_out,
	output logic             frame_last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [FH_W-1:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.sts       (sts),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	sem_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req_type),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_last (frame_last)
	);

endmodule

FILE: design/sem_check.sv
// Port-level checker for the Sobel RGB edge block, bound to the top level.
module sem_check
	import sem_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            req_type,
	input logic            out_valid,
	input logic            out_stall,
	input logic [CH_W-1:0] red_out,
	input logic            cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(red_out))
		else $error("stalled output payload changed");

	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type == REQ_PIXEL |=> in_stall && !cfg_ready)
		else $error("pixel transaction did not occupy the block");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !in_stall)
		else $error("configuration ready outside idle");

endmodule

bind sobel_edge_magnitude_rgb sem_check u_sem_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red_out   (red_out),
	.cfg_ready (cfg_ready)
);
